// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define TGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define TGD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TGD_ASSERT(lbl, prop, msg)
`define TGD_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ----- rtl/tgd_pkg.sv -----
// ----------------------------------------------------------------------------
// tgd_pkg
// Shared widths, register codes, types and limits of the tilt gesture detector.
// ----------------------------------------------------------------------------
package tgd_pkg;

  // field and state widths
  localparam int ANG_W      = 15;
  localparam int ACC_W      = 21;
  localparam int CNT_W      = 9;
  localparam int THR_W      = 14;
  localparam int SET_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int AVG_SAMPLES_DEF = 50;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PT = 3'd4;

  // register reset values (20 and 10 degrees in 1/64 degree)
  localparam logic [THR_W-1:0] ENTER_RST  = 14'd1280;
  localparam logic [THR_W-1:0] EXIT_RST   = 14'd640;
  localparam logic [SET_W-1:0] SETTLE_RST = 8'd20;
  localparam logic             INV_RL_RST = 1'b1;
  localparam logic             INV_PT_RST = 1'b0;

  // angle limits
  localparam logic signed [ANG_W-1:0] ANG_HI = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_LO = {1'b1, {(ANG_W-1){1'b0}}};

  // axis direction state and event code share one encoding
  typedef enum logic [1:0] {
    TILT_NONE = 2'd0,
    TILT_POS  = 2'd1,
    TILT_NEG  = 2'd2
  } tilt_t;

  // per-sample control shared by both axis lanes
  typedef struct packed {
    logic clear;    // recalibrate request on this sample
    logic accum;    // add sample into the average
    logic detect;   // run the hysteresis compare
    logic finish;   // sample completes calibration
    logic div_mul;  // centre scaling, multiply step
    logic div_fin;  // centre scaling, write step
  } lane_ctrl_t;

  // one result as held in the output register
  typedef struct packed {
    tilt_t roll_ev;
    tilt_t pitch_ev;
    logic  calibrating;
    logic  cal_done;
  } result_t;

endpackage

// ----- rtl/tgd_if.sv -----
// ----------------------------------------------------------------------------
// tgd_if
// Valid/ready channels for angle samples and gesture results.
// ----------------------------------------------------------------------------
interface tgd_in_if;
  import tgd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] roll_angle;
  logic signed [ANG_W-1:0] pitch_angle;
  logic                    recalibrate;

  modport source (output valid, roll_angle, pitch_angle, recalibrate, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, recalibrate, output ready);
endinterface

interface tgd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] roll_event;
  logic [1:0] pitch_event;
  logic       calibrating;
  logic       calibration_done;

  modport source (output valid, roll_event, pitch_event, calibrating, calibration_done,
                  input ready);
  modport sink   (input valid, roll_event, pitch_event, calibrating, calibration_done,
                  output ready);
endinterface

// ----- rtl/tgd_cal_ctrl.sv -----
// ----------------------------------------------------------------------------
// tgd_cal_ctrl
// Calibration sequencer: settle/average sample count and lane control.
// ----------------------------------------------------------------------------
module tgd_cal_ctrl import tgd_pkg::*; #(
  parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic             recal,
  input  logic [SET_W-1:0] settle,
  output lane_ctrl_t       ctrl,
  output logic             busy,
  output logic             cal_after,
  output logic             cal_done
);

  localparam logic [CNT_W-1:0] AVG_CNT = CNT_W'(AVG_SAMPLES);

  logic             cal_r, cal_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             div1_r, div2_r;

  logic             cal_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] limit;
  logic             finish_c;
  logic             accum_c;

  // a recalibrate request restarts the sequence before the sample is used
  always_comb begin
    cal_eff  = recal | cal_r;
    cnt_eff  = recal ? '0 : cnt_r;
    cnt_inc  = cnt_eff + CNT_W'(1);
    limit    = CNT_W'(settle) + AVG_CNT;
    accum_c  = cal_eff & (cnt_eff >= CNT_W'(settle));
    finish_c = cal_eff & (cnt_inc >= limit);
  end

  // next sequencer state
  always_comb begin
    cal_nxt = cal_r;
    cnt_nxt = cnt_r;
    if (take && cal_eff) begin
      cnt_nxt = cnt_inc;
      cal_nxt = !finish_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r  <= 1'b1;
      cnt_r  <= '0;
      div1_r <= 1'b0;
      div2_r <= 1'b0;
    end else begin
      cal_r  <= cal_nxt;
      cnt_r  <= cnt_nxt;
      div1_r <= take & finish_c;
      div2_r <= div1_r;
    end
  end

  // lane control for this sample
  always_comb begin
    ctrl.clear   = take & recal;
    ctrl.accum   = take & accum_c;
    ctrl.detect  = take & !cal_eff;
    ctrl.finish  = take & finish_c;
    ctrl.div_mul = div1_r;
    ctrl.div_fin = div2_r;
  end

  assign busy      = div1_r | div2_r;
  assign cal_after = cal_eff & !finish_c;
  assign cal_done  = finish_c;

endmodule

// ----- rtl/tgd_lane.sv -----
// ----------------------------------------------------------------------------
// tgd_lane
// One axis: inversion, calibration sum, centre scaling and hysteresis.
// ----------------------------------------------------------------------------
module tgd_lane import tgd_pkg::*; #(
  parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lane_ctrl_t              ctrl,
  input  logic signed [ANG_W-1:0] angle,
  input  logic                    invert,
  input  logic [THR_W-1:0]        enter_thr,
  input  logic [THR_W-1:0]        exit_thr,
  output tilt_t                   tilt_ev
);

  // reciprocal of the sample count, exact for any accumulator magnitude
  localparam int DIV_SHIFT = ACC_W + $clog2(AVG_SAMPLES);
  localparam int REC_W     = ACC_W + 1;
  localparam int PROD_W    = DIV_SHIFT + ACC_W;
  localparam int RECIP     = (2**DIV_SHIFT + AVG_SAMPLES - 1) / AVG_SAMPLES;
  localparam logic [REC_W-1:0] RECIP_V = REC_W'(RECIP);

  localparam int REL_W = ANG_W + 2;

  localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0] accum_r, accum_nxt;
  logic signed [ANG_W-1:0] centre_r, centre_nxt;
  tilt_t                   dir_r, dir_nxt;
  logic [PROD_W-1:0]       prod_r;
  logic                    neg_r;

  logic signed [ANG_W-1:0] ang_use;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W:0]   sum;
  logic [ACC_W-1:0]        mag;
  logic [ACC_W-1:0]        quo;
  logic signed [ACC_W:0]   quo_s;
  logic signed [REL_W-1:0] rel;
  logic signed [REL_W-1:0] rel_mag;
  logic signed [REL_W-1:0] en_s;
  logic signed [REL_W-1:0] ex_s;

  // optional negation, most negative code saturates
  always_comb begin
    if (!invert)
      ang_use = angle;
    else if (angle == ANG_LO)
      ang_use = ANG_HI;
    else
      ang_use = -angle;
  end

  // saturating calibration sum
  always_comb begin
    base      = ctrl.clear ? '0 : accum_r;
    sum       = (ACC_W+1)'(base) + (ACC_W+1)'(ang_use);
    accum_nxt = accum_r;
    if (ctrl.accum) begin
      if (sum > (ACC_W+1)'(ACC_HI))
        accum_nxt = ACC_HI;
      else if (sum < (ACC_W+1)'(ACC_LO))
        accum_nxt = ACC_LO;
      else
        accum_nxt = ACC_W'(sum);
    end else if (ctrl.clear) begin
      accum_nxt = '0;
    end
  end

  // centre scaling: multiply magnitude by reciprocal, then shift and sign
  assign mag = accum_r[ACC_W-1] ? ACC_W'(-accum_r) : ACC_W'(accum_r);

  always_comb begin
    quo        = prod_r[DIV_SHIFT +: ACC_W];
    quo_s      = neg_r ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    centre_nxt = centre_r;
    if (ctrl.div_fin) begin
      if (quo_s > (ACC_W+1)'(ANG_HI))
        centre_nxt = ANG_HI;
      else if (quo_s < (ACC_W+1)'(ANG_LO))
        centre_nxt = ANG_LO;
      else
        centre_nxt = ANG_W'(quo_s);
    end
  end

  // hysteresis detector on angle relative to centre
  always_comb begin
    rel     = REL_W'(ang_use) - REL_W'(centre_r);
    rel_mag = (rel < 0) ? -rel : rel;
    en_s    = signed'(REL_W'(enter_thr));
    ex_s    = signed'(REL_W'(exit_thr));
    dir_nxt = dir_r;
    tilt_ev = TILT_NONE;
    if (ctrl.finish) begin
      dir_nxt = TILT_NONE;
    end else if (ctrl.detect) begin
      if (dir_r == TILT_NONE) begin
        if (rel > en_s) begin
          dir_nxt = TILT_POS;
          tilt_ev = TILT_POS;
        end else if (rel < -en_s) begin
          dir_nxt = TILT_NEG;
          tilt_ev = TILT_NEG;
        end
      end else if (rel_mag < ex_s) begin
        dir_nxt = TILT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r  <= '0;
      centre_r <= '0;
      dir_r    <= TILT_NONE;
    end else begin
      accum_r  <= accum_nxt;
      centre_r <= centre_nxt;
      dir_r    <= dir_nxt;
    end
  end

  // product register, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.div_mul) begin
      prod_r <= PROD_W'(mag) * PROD_W'(RECIP_V);
      neg_r  <= accum_r[ACC_W-1];
    end
  end

endmodule

// ----- rtl/tgd_merge.sv -----
// ----------------------------------------------------------------------------
// tgd_merge
// Combines lane events and calibration status into the output register.
// ----------------------------------------------------------------------------
module tgd_merge import tgd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  tilt_t   roll_ev,
  input  tilt_t   pitch_ev,
  input  logic    cal_after,
  input  logic    cal_done,
  input  logic    out_ready,
  output logic    slot_free,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // register frees when empty or being drained this cycle
  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take)
      valid_nxt = 1'b1;
    else if (out_ready)
      valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= 1'b0;
    else
      valid_r <= valid_nxt;
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_r.roll_ev     <= roll_ev;
      res_r.pitch_ev    <= pitch_ev;
      res_r.calibrating <= cal_after;
      res_r.cal_done    <= cal_done;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/tilt_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// tilt_gesture_detector
// Two-axis tilt gesture detector with auto-calibrated centre and hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one roll/pitch sample (signed, 1/64 degree) and a
//   recalibrate flag per request; out_ch returns exactly one result request
//   per sample: roll/pitch events, calibrating and calibration_done.
//   cfg_we/cfg_index/cfg_wdata write the thresholds, settle count and the
//   per-axis inversion; write only while the block is idle.
// Flow:
//   A result is valid the cycle after its sample is accepted. One sample per
//   cycle is taken while the output register can drain; the sample completing
//   calibration holds in_ch.ready low while the averaged centre is scaled
//   (reciprocal multiply cycle, then shift/saturate and centre write).
// Reset:
//   Registers return to their defaults and calibration starts at once:
//   settle samples are skipped, then AVG_SAMPLES samples are averaged.
// Stall:
//   One output register; in_ch.ready follows out_ch.ready whenever the
//   register is full, so no result is dropped and inputs hold off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tilt_gesture_detector import tgd_pkg::*; #(
  parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tgd_in_if.sink                in_ch,
  tgd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [THR_W-1:0] enter_r, enter_nxt;
  logic [THR_W-1:0] exit_r, exit_nxt;
  logic [SET_W-1:0] settle_r, settle_nxt;
  logic             inv_rl_r, inv_rl_nxt;
  logic             inv_pt_r, inv_pt_nxt;

  lane_ctrl_t lane_ctrl;
  logic       busy;
  logic       slot_free;
  logic       in_acc;
  logic       cal_after;
  logic       cal_done;
  tilt_t      roll_ev;
  tilt_t      pitch_ev;
  result_t    out_res;

  // configuration register decode
  always_comb begin
    enter_nxt  = enter_r;
    exit_nxt   = exit_r;
    settle_nxt = settle_r;
    inv_rl_nxt = inv_rl_r;
    inv_pt_nxt = inv_pt_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTER:  enter_nxt  = cfg_wdata[THR_W-1:0];
        CFG_EXIT:   exit_nxt   = cfg_wdata[THR_W-1:0];
        CFG_SETTLE: settle_nxt = cfg_wdata[SET_W-1:0];
        CFG_INV_RL: inv_rl_nxt = cfg_wdata[0];
        CFG_INV_PT: inv_pt_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_r  <= ENTER_RST;
      exit_r   <= EXIT_RST;
      settle_r <= SETTLE_RST;
      inv_rl_r <= INV_RL_RST;
      inv_pt_r <= INV_PT_RST;
    end else begin
      enter_r  <= enter_nxt;
      exit_r   <= exit_nxt;
      settle_r <= settle_nxt;
      inv_rl_r <= inv_rl_nxt;
      inv_pt_r <= inv_pt_nxt;
    end
  end

  // input handshake
  assign in_ch.ready = slot_free & !busy;
  assign in_acc      = in_ch.valid & in_ch.ready;

  // calibration sequencer
  tgd_cal_ctrl #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_acc),
    .recal     (in_ch.recalibrate),
    .settle    (settle_r),
    .ctrl      (lane_ctrl),
    .busy      (busy),
    .cal_after (cal_after),
    .cal_done  (cal_done)
  );

  // axis lanes
  tgd_lane #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .angle     (in_ch.roll_angle),
    .invert    (inv_rl_r),
    .enter_thr (enter_r),
    .exit_thr  (exit_r),
    .tilt_ev   (roll_ev)
  );

  tgd_lane #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .angle     (in_ch.pitch_angle),
    .invert    (inv_pt_r),
    .enter_thr (enter_r),
    .exit_thr  (exit_r),
    .tilt_ev   (pitch_ev)
  );

  // result merge and output register
  tgd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_acc),
    .roll_ev   (roll_ev),
    .pitch_ev  (pitch_ev),
    .cal_after (cal_after),
    .cal_done  (cal_done),
    .out_ready (out_ch.ready),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_res   (out_res)
  );

  assign out_ch.roll_event       = out_res.roll_ev;
  assign out_ch.pitch_event      = out_res.pitch_ev;
  assign out_ch.calibrating      = out_res.calibrating;
  assign out_ch.calibration_done = out_res.cal_done;

  // checks
  `TGD_ASSERT(a_centre_pause, lane_ctrl.finish |=> !in_acc ##1 !in_acc, "sample taken during centre scaling")
  `TGD_ASSERT(a_scale_seq, lane_ctrl.finish |=> lane_ctrl.div_mul ##1 lane_ctrl.div_fin, "centre scaling out of step")
  `TGD_ASSERT(a_cal_quiet, out_ch.valid && (out_ch.calibrating || out_ch.calibration_done) |-> out_ch.roll_event == TILT_NONE && out_ch.pitch_event == TILT_NONE, "event during calibration")
  `TGD_ASSERT_NEVER(a_done_excl, out_ch.valid && out_ch.calibration_done && out_ch.calibrating, "done while still calibrating")

endmodule

// ----- verif/tilt_gesture_detector_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_gesture_detector_test
// Self-checking bench for the two-axis tilt gesture detector. A scoreboard
// class tracks calibration, the averaged centre and the per-axis hysteresis,
// and checks every result request against its own prediction. Stimulus covers
// angle extremes, exact threshold edges, accumulator and centre saturation,
// settle count changes mid-calibration and random gesture streams under
// several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
import tgd_pkg::*;

// predicts one result per accepted sample and checks the results in order
class tilt_scoreboard;
  localparam int ANG_MAX = 2 ** (ANG_W - 1) - 1;
  localparam int ANG_MIN = -(2 ** (ANG_W - 1));
  localparam int ACC_MAX = 2 ** (ACC_W - 1) - 1;
  localparam int ACC_MIN = -(2 ** (ACC_W - 1));

  // register copies
  logic [THR_W-1:0] enter_thr;
  logic [THR_W-1:0] exit_thr;
  logic [SET_W-1:0] settle_cnt;
  logic             inv_roll;
  logic             inv_pitch;

  // block state
  logic                    cal_active;
  logic [CNT_W-1:0]        cal_count;
  logic signed [ACC_W-1:0] roll_acc;
  logic signed [ACC_W-1:0] pitch_acc;
  logic signed [ANG_W-1:0] roll_ctr;
  logic signed [ANG_W-1:0] pitch_ctr;
  tilt_t                   roll_dir;
  tilt_t                   pitch_dir;

  result_t     expected_q[$];
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned events_seen;
  int unsigned calibrations;

  function new();
    enter_thr  = ENTER_RST;
    exit_thr   = EXIT_RST;
    settle_cnt = SETTLE_RST;
    inv_roll   = INV_RL_RST;
    inv_pitch  = INV_PT_RST;
    cal_active = 1'b1;
    cal_count  = '0;
    roll_acc   = '0;
    pitch_acc  = '0;
    roll_ctr   = '0;
    pitch_ctr  = '0;
    roll_dir   = TILT_NONE;
    pitch_dir  = TILT_NONE;
    mismatches = 0;
    results_checked = 0;
    events_seen = 0;
    calibrations = 0;
  endfunction

  static function int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // bits above a register's width are dropped, unknown indexes ignored
  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ENTER:  enter_thr = data[THR_W-1:0];
      CFG_EXIT:   exit_thr = data[THR_W-1:0];
      CFG_SETTLE: settle_cnt = data[SET_W-1:0];
      CFG_INV_RL: inv_roll = data[0];
      CFG_INV_PT: inv_pitch = data[0];
      default: ;
    endcase
  endfunction

  // one axis of the hysteresis: fire once past enter, re-arm below exit
  function tilt_t hysteresis(int rel, inout tilt_t dir);
    int mag;
    if (dir == TILT_NONE) begin
      if (rel > int'(enter_thr)) begin
        dir = TILT_POS;
        return TILT_POS;
      end
      if (rel < -int'(enter_thr)) begin
        dir = TILT_NEG;
        return TILT_NEG;
      end
    end else begin
      mag = (rel < 0) ? -rel : rel;
      if (mag < int'(exit_thr)) dir = TILT_NONE;
    end
    return TILT_NONE;
  endfunction

  function void note_sample(logic signed [ANG_W-1:0] roll_in,
                            logic signed [ANG_W-1:0] pitch_in, logic recal);
    int      roll;
    int      pitch;
    result_t res;
    roll  = roll_in;
    pitch = pitch_in;
    res.roll_ev  = TILT_NONE;
    res.pitch_ev = TILT_NONE;
    res.cal_done = 1'b0;

    // negating the most negative angle saturates
    if (inv_roll) roll = clip(-roll, ANG_MIN, ANG_MAX);
    if (inv_pitch) pitch = clip(-pitch, ANG_MIN, ANG_MAX);

    if (recal) begin
      cal_active = 1'b1;
      cal_count  = '0;
      roll_acc   = '0;
      pitch_acc  = '0;
    end

    if (cal_active) begin
      if (cal_count >= settle_cnt) begin
        roll_acc  = ACC_W'(clip(int'(roll_acc) + roll, ACC_MIN, ACC_MAX));
        pitch_acc = ACC_W'(clip(int'(pitch_acc) + pitch, ACC_MIN, ACC_MAX));
      end
      cal_count = cal_count + 1'b1;
      // divisor stays fixed even if the settle count moved meanwhile
      if (int'(cal_count) >= int'(settle_cnt) + AVG_SAMPLES_DEF) begin
        roll_ctr   = ANG_W'(clip(int'(roll_acc) / AVG_SAMPLES_DEF, ANG_MIN, ANG_MAX));
        pitch_ctr  = ANG_W'(clip(int'(pitch_acc) / AVG_SAMPLES_DEF, ANG_MIN, ANG_MAX));
        cal_active = 1'b0;
        roll_dir   = TILT_NONE;
        pitch_dir  = TILT_NONE;
        res.cal_done = 1'b1;
        calibrations++;
      end
    end else begin
      res.roll_ev  = hysteresis(roll - int'(roll_ctr), roll_dir);
      res.pitch_ev = hysteresis(pitch - int'(pitch_ctr), pitch_dir);
      if (res.roll_ev != TILT_NONE) events_seen++;
      if (res.pitch_ev != TILT_NONE) events_seen++;
    end
    res.calibrating = cal_active;
    expected_q.push_back(res);
  endfunction

  function void check_result(logic [1:0] roll_ev, logic [1:0] pitch_ev,
                             logic calibrating, logic cal_done);
    result_t want;
    results_checked++;
    if (expected_q.size() == 0) begin
      if (mismatches < 10)
        $display("[%0t] result with no sample waiting: ", $realtime,
                 "roll %0d pitch %0d cal %0b done %0b",
                 roll_ev, pitch_ev, calibrating, cal_done);
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      if (roll_ev !== want.roll_ev || pitch_ev !== want.pitch_ev ||
          calibrating !== want.calibrating || cal_done !== want.cal_done) begin
        if (mismatches < 10)
          $display("[%0t] mismatch: expected roll %0d pitch %0d cal %0b done %0b, ",
                   $realtime, want.roll_ev, want.pitch_ev, want.calibrating,
                   want.cal_done, "got roll %0d pitch %0d cal %0b done %0b",
                   roll_ev, pitch_ev, calibrating, cal_done);
        mismatches++;
      end
    end
  endfunction
endclass

module tilt_gesture_detector_test;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int HOLD_CYCLES   = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tgd_in_if  in_ch();
  tgd_out_if out_ch();

  tilt_gesture_detector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tilt_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned phase_count = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  bit          steady = 1'b0;
  int          cur_enter = int'(ENTER_RST);
  int          cur_exit  = int'(EXIT_RST);
  int          roll_base = 0;
  int          pitch_base = 0;

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.roll_event, out_ch.pitch_event, out_ch.calibrating,
                      out_ch.calibration_done);
  end

  // clamp to the angle field range
  function automatic logic signed [ANG_W-1:0] to_angle(int v);
    if (v > int'(ANG_HI)) return ANG_HI;
    if (v < int'(ANG_LO)) return ANG_LO;
    return ANG_W'(v);
  endfunction

  function automatic int jit(int j);
    return int'($urandom_range(0, 2 * j)) - j;
  endfunction

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int stall_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!steady && $urandom_range(0, 99) < 30) begin
        out_ch.ready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat (steady ? 16 : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  // one sample request, returns once the block has taken it
  task automatic send_sample(int roll, int pitch, bit recal);
    int gap;
    gap = steady ? 0 : sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.roll_angle  <= to_angle(roll);
    in_ch.pitch_angle <= to_angle(pitch);
    in_ch.recalibrate <= recal;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(to_angle(roll), to_angle(pitch), recal);
    items_sent++;
  endtask

  // stop offering and let every result and the centre scaling finish
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // all five registers, junk in the unused upper bits, sometimes a stray index
  task automatic apply_config(int enter_v, int exit_v, int settle_v, bit inv_r, bit inv_p);
    write_reg(CFG_ENTER, CFG_DATA_W'(enter_v));
    write_reg(CFG_EXIT, CFG_DATA_W'(exit_v));
    write_reg(CFG_SETTLE, CFG_DATA_W'(($urandom_range(0, 63) << SET_W) | settle_v));
    write_reg(CFG_INV_RL, CFG_DATA_W'(($urandom_range(0, 8191) << 1) | inv_r));
    write_reg(CFG_INV_PT, CFG_DATA_W'(($urandom_range(0, 8191) << 1) | inv_p));
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'(CFG_INV_PT + 1 + $urandom_range(0, 2)),
                CFG_DATA_W'($urandom_range(0, 16383)));
    cfg_we <= 1'b0;
    cur_enter = enter_v;
    cur_exit  = exit_v;
  endtask

  // feeds samples near a centre until calibration has completed
  task automatic calibrate_around(int roll_c, int pitch_c, int jitter, bit restart);
    roll_base  = roll_c;
    pitch_base = pitch_c;
    if (restart) send_sample(roll_c + jit(jitter), pitch_c + jit(jitter), 1'b1);
    while (sb.cal_active) send_sample(roll_c + jit(jitter), pitch_c + jit(jitter), 1'b0);
  endtask

  // level offset for a gesture: past enter, below exit, in between, or anywhere
  function automatic int pick_level();
    int mag;
    int lo;
    int hi;
    lo = (cur_exit < cur_enter) ? cur_exit : cur_enter;
    hi = (cur_exit < cur_enter) ? cur_enter : cur_exit;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: mag = cur_enter + $urandom_range(1, 600);
      4, 5, 6:    mag = $urandom_range(0, cur_exit);
      7, 8:       mag = $urandom_range(lo, hi);
      default:    mag = $urandom_range(0, 16383);
    endcase
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  // tilt gestures: each axis holds a level for a few samples, then moves on
  task automatic gesture_run(int n);
    int roll_lvl;
    int pitch_lvl;
    int roll_left;
    int pitch_left;
    roll_left  = 0;
    pitch_left = 0;
    repeat (n) begin
      if (roll_left == 0) begin
        roll_lvl  = pick_level();
        roll_left = $urandom_range(1, 6);
      end
      if (pitch_left == 0) begin
        pitch_lvl  = pick_level();
        pitch_left = $urandom_range(1, 6);
      end
      send_sample(roll_base + roll_lvl + jit(8), pitch_base + pitch_lvl + jit(8),
                  $urandom_range(0, 249) == 0);
      roll_left--;
      pitch_left--;
    end
  endtask

  // full-range angles, frequent recalibration
  task automatic noise_run(int n);
    repeat (n)
      send_sample(int'($urandom_range(0, 32767)) - 16384,
                  int'($urandom_range(0, 32767)) - 16384, $urandom_range(0, 24) == 0);
  endtask

  initial begin
    int unsigned random_start;
    int          enter_v;
    int          exit_v;
    int          settle_v;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.roll_angle  <= '0;
    in_ch.pitch_angle <= '0;
    in_ch.recalibrate <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: calibrating from reset, constant input gives exact centres
    // (roll inverted: centre -100, pitch centre -200)
    calibrate_around(100, -200, 0, 1'b0);

    // extremes, including the most negative angle negated
    send_sample(-16384, 16383, 1'b0);
    send_sample(0, 0, 1'b0);
    send_sample(16383, -16384, 1'b0);
    send_sample(100, -200, 1'b0);
    // relative angle exactly at enter does not fire, one above does
    send_sample(-1180, 1080, 1'b0);
    send_sample(-1181, 1081, 1'b0);
    // exactly at exit stays armed off, one below re-arms
    send_sample(-540, 440, 1'b0);
    send_sample(-539, 439, 1'b0);
    send_sample(1380, -1480, 1'b0);
    send_sample(1381, -1481, 1'b0);
    send_sample(11520, -11520, 1'b0);
    send_sample(100, -200, 1'b0);
    send_sample(-11520, 11520, 1'b0);
    // recalibrate request, then new settings while calibration is under way
    send_sample(100, -200, 1'b1);
    wait_drained();
    apply_config(2000, 300, 3, 1'b0, 1'b1);
    calibrate_around(-3000, 2500, 40, 1'b0);
    gesture_run(10);

    // accumulator saturation: 49 summed, settle raised, 50 more summed
    wait_drained();
    apply_config(1280, 640, 0, 1'b0, 1'b0);
    send_sample(16383, -16384, 1'b1);
    repeat (48) send_sample(16383, -16384, 1'b0);
    wait_drained();
    write_reg(CFG_SETTLE, CFG_DATA_W'(255));
    cfg_we <= 1'b0;
    calibrate_around(16383, -16384, 0, 1'b0);
    send_sample(-16384, 16383, 1'b0);
    send_sample(-16384, 16383, 1'b0);

    // settle lowered mid-calibration finishes at once on the next sample
    wait_drained();
    apply_config(1500, 1500, 100, 1'b1, 1'b1);
    send_sample(500, -500, 1'b1);
    repeat (59) send_sample(500 + jit(20), -500 + jit(20), 1'b0);
    wait_drained();
    write_reg(CFG_SETTLE, CFG_DATA_W'(5));
    cfg_we <= 1'b0;
    calibrate_around(500, -500, 20, 1'b0);
    gesture_run(12);

    // random phases under varied settings
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       enter_v = 0;
        1:       enter_v = 11520;
        2:       enter_v = 16383;
        default: enter_v = $urandom_range(200, 3000);
      endcase
      case ($urandom_range(0, 5))
        0:       exit_v = 0;
        1:       exit_v = 11520;
        2:       exit_v = 16383;
        default: exit_v = $urandom_range(0, enter_v);
      endcase
      if (phase_count == 2)
        settle_v = 255;
      else if ($urandom_range(0, 3) == 0)
        settle_v = $urandom_range(0, 40);
      else
        settle_v = $urandom_range(0, 6);

      wait_drained();
      steady = ($urandom_range(0, 3) == 0);
      if (phase_count == 1) begin
        steady = 1'b0;
        hold_requests++;
      end
      apply_config(enter_v, exit_v, settle_v, $urandom_range(0, 1), $urandom_range(0, 1));
      calibrate_around(int'($urandom_range(0, 8000)) - 4000,
                       int'($urandom_range(0, 8000)) - 4000, $urandom_range(0, 60), 1'b1);
      gesture_run($urandom_range(100, 200));
      noise_run($urandom_range(10, 30));
      gesture_run($urandom_range(40, 80));
      phase_count++;
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Run covered %0d samples and %0d results, %0d calibrations, %0d tilt events.",
             items_sent, sb.results_checked, sb.calibrations, sb.events_seen);
    $display("Random register settings: %0d, mismatches: %0d.", phase_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tgd_pkg.sv
rtl/tgd_if.sv
rtl/tgd_cal_ctrl.sv
rtl/tgd_lane.sv
rtl/tgd_merge.sv
rtl/tilt_gesture_detector.sv
verif/tilt_gesture_detector_test.sv
